>>> sv/topk_pkg.sv
// Shared constants, types and helpers for the top-k frequency tracker.
package topk_pkg;

	localparam int MAX_KEPT = 16;
	localparam int KEPT_W   = $clog2(MAX_KEPT + 1);
	localparam int IDX_W    = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int CFG_W    = 5;
	localparam int TAG_W    = 32;
	localparam int CNT_W    = 32;
	localparam int RANK_W   = 4;

	localparam logic CMD_OFFER = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_READ
	} state_t;

	typedef struct packed {
		logic             insert;
		logic             set_kept;
		logic             load;
		logic             last;
		logic             empty;
		logic [IDX_W-1:0] rd_idx;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [KEPT_W-1:0] fill;
		logic              out_free;
	} dp_status_t;

	// A written zero acts as one; anything above the list depth saturates.
	function automatic logic [KEPT_W-1:0] clamp_kept(input logic [CFG_W-1:0] v);
		logic [KEPT_W-1:0] r;
		if (v == '0) begin
			r = KEPT_W'(1);
		end else if (int'(v) > MAX_KEPT) begin
			r = KEPT_W'(MAX_KEPT);
		end else begin
			r = KEPT_W'(v);
		end
		return r;
	endfunction

endpackage

>>> sv/topk_ctrl.sv
// Controller: accepts items and config writes, sequences the read-out.
module topk_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	input  logic                   command,
	input  logic                   cfg_valid,
	output logic                   item_stall,
	output logic                   cfg_ready,
	input  topk_pkg::dp_status_t   status,
	output topk_pkg::ctrl_cmd_t    cmd
);

	topk_pkg::state_t state_q, state_next;
	logic [topk_pkg::IDX_W-1:0] rd_idx_q;
	logic [topk_pkg::IDX_W-1:0] last_idx;
	logic accept;
	logic empty;
	logic at_last;

	assign accept   = item_valid && !item_stall;
	assign empty    = (status.fill == '0);
	assign last_idx = topk_pkg::IDX_W'(status.fill - topk_pkg::KEPT_W'(1));
	assign at_last  = empty || (rd_idx_q == last_idx);

	always_comb begin
		state_next = state_q;
		case (state_q)
			topk_pkg::ST_IDLE: begin
				if (accept && command == topk_pkg::CMD_READ) begin
					state_next = topk_pkg::ST_READ;
				end
			end
			topk_pkg::ST_READ: begin
				if (status.out_free && at_last) begin
					state_next = topk_pkg::ST_IDLE;
				end
			end
			default: state_next = topk_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		item_stall   = 1'b1;
		cfg_ready    = 1'b0;
		cmd          = '0;
		cmd.rd_idx   = rd_idx_q;
		cmd.last     = at_last;
		cmd.empty    = empty;
		case (state_q)
			topk_pkg::ST_IDLE: begin
				// hold items off while a config transfer takes the cycle
				item_stall   = cfg_valid;
				cfg_ready    = 1'b1;
				cmd.set_kept = cfg_valid;
				cmd.insert   = item_valid && command == topk_pkg::CMD_OFFER && !cfg_valid;
			end
			topk_pkg::ST_READ: begin
				cmd.load = status.out_free;
			end
			default: begin
				item_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= topk_pkg::ST_IDLE;
			rd_idx_q <= '0;
		end else begin
			state_q <= state_next;
			if (state_q == topk_pkg::ST_IDLE) begin
				rd_idx_q <= '0;
			end else if (cmd.load) begin
				rd_idx_q <= rd_idx_q + topk_pkg::IDX_W'(1);
			end
		end
	end

	// Read-out never runs past the held entries.
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == topk_pkg::ST_READ && !empty) |->
		(topk_pkg::KEPT_W'(rd_idx_q) < status.fill))
		else $error("read index beyond fill level");

	// No list change while a read-out is in flight.
	a_no_insert_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == topk_pkg::ST_READ) |-> (!cmd.insert && !cmd.set_kept))
		else $error("list modified during read-out");

	// Final transfer of a read-out returns the controller to idle.
	a_last_ends_read: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && cmd.last) |=> (state_q == topk_pkg::ST_IDLE))
		else $error("read-out did not end after last entry");

endmodule

>>> sv/topk_dpath.sv
// Datapath: ranked cell chain, fill and limit registers, result register.
module topk_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  topk_pkg::ctrl_cmd_t               cmd,
	output topk_pkg::dp_status_t              status,
	input  logic [topk_pkg::TAG_W-1:0]        offered_tag,
	input  logic [topk_pkg::CNT_W-1:0]        offered_count,
	input  logic [topk_pkg::CFG_W-1:0]        kept_count,
	input  logic                              result_stall,
	output logic                              result_valid,
	output logic                              entry_valid,
	output logic [topk_pkg::RANK_W-1:0]       rank,
	output logic [topk_pkg::TAG_W-1:0]        entry_tag,
	output logic [topk_pkg::CNT_W-1:0]        entry_count,
	output logic                              last
);

	logic [topk_pkg::TAG_W-1:0]  tags_q   [topk_pkg::MAX_KEPT];
	logic [topk_pkg::CNT_W-1:0]  counts_q [topk_pkg::MAX_KEPT];
	logic [topk_pkg::KEPT_W-1:0] fill_q;
	logic [topk_pkg::KEPT_W-1:0] kept_q;
	logic [topk_pkg::MAX_KEPT-1:0] lt;
	logic [topk_pkg::MAX_KEPT-1:0] ge;
	logic full;
	logic discard;
	logic write_en;

	logic                        out_valid_q;
	logic                        out_entry_valid_q;
	logic [topk_pkg::RANK_W-1:0] out_rank_q;
	logic [topk_pkg::TAG_W-1:0]  out_tag_q;
	logic [topk_pkg::CNT_W-1:0]  out_count_q;
	logic                        out_last_q;

	// Each cell compares against the offer; the list is sorted, so ge is a
	// contiguous run from the insertion point to the end.
	always_comb begin
		for (int i = 0; i < topk_pkg::MAX_KEPT; i++) begin
			lt[i] = (topk_pkg::KEPT_W'(i) < fill_q) && (counts_q[i] < offered_count);
			ge[i] = lt[i] || (topk_pkg::KEPT_W'(i) >= fill_q);
		end
	end

	assign full     = (fill_q >= kept_q);
	assign discard  = full && !(|lt);
	assign write_en = cmd.insert && !discard;

	always_ff @(posedge clk) begin
		if (write_en) begin
			for (int i = 0; i < topk_pkg::MAX_KEPT; i++) begin
				if (i == 0) begin
					if (ge[0]) begin
						tags_q[0]   <= offered_tag;
						counts_q[0] <= offered_count;
					end
				end else if (ge[i] && !ge[i-1]) begin
					tags_q[i]   <= offered_tag;
					counts_q[i] <= offered_count;
				end else if (ge[i]) begin
					tags_q[i]   <= tags_q[i-1];
					counts_q[i] <= counts_q[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			kept_q <= topk_pkg::KEPT_W'(topk_pkg::MAX_KEPT);
		end else if (cmd.set_kept) begin
			fill_q <= '0;
			kept_q <= topk_pkg::clamp_kept(kept_count);
		end else if (write_en && !full) begin
			fill_q <= fill_q + topk_pkg::KEPT_W'(1);
		end
	end

	// Result register: hold while stalled, drop after the transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_entry_valid_q <= !cmd.empty;
			out_last_q        <= cmd.last;
			if (cmd.empty) begin
				out_rank_q  <= '0;
				out_tag_q   <= '0;
				out_count_q <= '0;
			end else begin
				out_rank_q  <= topk_pkg::RANK_W'(cmd.rd_idx);
				out_tag_q   <= tags_q[cmd.rd_idx];
				out_count_q <= counts_q[cmd.rd_idx];
			end
		end
	end

	assign status.fill     = fill_q;
	assign status.out_free = !out_valid_q || !result_stall;

	assign result_valid = out_valid_q;
	assign entry_valid  = out_entry_valid_q;
	assign rank         = out_rank_q;
	assign entry_tag    = out_tag_q;
	assign entry_count  = out_count_q;
	assign last         = out_last_q;

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q <= kept_q) && (kept_q >= topk_pkg::KEPT_W'(1)) &&
		(kept_q <= topk_pkg::KEPT_W'(topk_pkg::MAX_KEPT)))
		else $error("fill level or limit out of range");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q >= topk_pkg::KEPT_W'(2)) |-> (counts_q[0] >= counts_q[1]))
		else $error("ranked list out of order");

	a_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.insert && !cmd.set_kept && !full) |=>
		(fill_q == $past(fill_q) + topk_pkg::KEPT_W'(1)))
		else $error("list did not grow on insert");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result_stall) |-> !cmd.load)
		else $error("result register overwritten while stalled");

endmodule

>>> sv/top_k_frequency_tracker.sv
// Top level of the top-k frequency tracker.
// Keeps up to kept_count (tag, count) entries sorted by descending count, ties in arrival
// order. A new item is accepted every cycle while idle and cfg_valid is low. On an offer
// (command 0) all cells compare against the offered count at once and shift in a single
// step. A read (command 1) stalls the item channel and emits max(1, fill) results, one per
// cycle when result_stall stays low, through a single result register that reads one cell
// per cycle; the item channel reopens after the last result is loaded. Writing kept_count
// (0 acts as 1, values above 16 saturate) empties the list; write it only while idle.
module top_k_frequency_tracker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  logic                        command,
	input  logic [topk_pkg::TAG_W-1:0]  offered_tag,
	input  logic [topk_pkg::CNT_W-1:0]  offered_count,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [topk_pkg::CFG_W-1:0]  kept_count,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic                        entry_valid,
	output logic [topk_pkg::RANK_W-1:0] rank,
	output logic [topk_pkg::TAG_W-1:0]  entry_tag,
	output logic [topk_pkg::CNT_W-1:0]  entry_count,
	output logic                        last
);

	topk_pkg::ctrl_cmd_t  cmd;
	topk_pkg::dp_status_t status;

	topk_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.command    (command),
		.cfg_valid  (cfg_valid),
		.item_stall (item_stall),
		.cfg_ready  (cfg_ready),
		.status     (status),
		.cmd        (cmd)
	);

	topk_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.offered_tag   (offered_tag),
		.offered_count (offered_count),
		.kept_count    (kept_count),
		.result_stall  (result_stall),
		.result_valid  (result_valid),
		.entry_valid   (entry_valid),
		.rank          (rank),
		.entry_tag     (entry_tag),
		.entry_count   (entry_count),
		.last          (last)
	);

endmodule

>>> dv/top_k_frequency_tracker_tb.sv
// Self-checking testbench for the top-k frequency tracker: ranked-list predictor and random traffic.
module top_k_frequency_tracker_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                        valid;
		logic [topk_pkg::RANK_W-1:0] pos;
		logic [topk_pkg::TAG_W-1:0]  tag;
		logic [topk_pkg::CNT_W-1:0]  cnt;
		logic                        tail;
	} entry_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t                  kind;
		logic                       cmd;
		logic [topk_pkg::TAG_W-1:0] tag;
		logic [topk_pkg::CNT_W-1:0] cnt;
		logic [topk_pkg::CFG_W-1:0] kept;
		logic                       typed;
		entry_t                     want;
	} row_t;

	localparam entry_t NO_ENTRY  = '{1'b0, 4'd0, 32'd0, 32'd0, 1'b1};
	localparam entry_t TOP_ENTRY = '{1'b1, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1};
	localparam int N_ROWS        = 26;
	localparam int N_PHASES      = 10;
	localparam int PHASE_ITEMS   = 24;
	localparam int SETTLE_CYCLES = 8;

	logic                        clk           = 1'b0;
	logic                        arst_n        = 1'b0;
	logic                        item_valid    = 1'b0;
	logic                        command       = topk_pkg::CMD_OFFER;
	logic [topk_pkg::TAG_W-1:0]  offered_tag   = '0;
	logic [topk_pkg::CNT_W-1:0]  offered_count = '0;
	logic                        cfg_valid     = 1'b0;
	logic [topk_pkg::CFG_W-1:0]  kept_count    = '0;
	logic                        result_stall  = 1'b0;
	logic                        item_stall;
	logic                        cfg_ready;
	logic                        result_valid;
	logic                        entry_valid;
	logic [topk_pkg::RANK_W-1:0] rank;
	logic [topk_pkg::TAG_W-1:0]  entry_tag;
	logic [topk_pkg::CNT_W-1:0]  entry_count;
	logic                        last;

	// predicted list contents and setting
	logic [topk_pkg::TAG_W-1:0] held_tag [topk_pkg::MAX_KEPT];
	logic [topk_pkg::CNT_W-1:0] held_cnt [topk_pkg::MAX_KEPT];
	int               held_fill  = 0;
	int               kept_limit = topk_pkg::MAX_KEPT;
	entry_t           pending_entries [$];
	int               mismatches = 0;
	bit               quiet      = 1'b0;
	int               hold_left  = 0;

	row_t dir_rows [N_ROWS] = '{
		'{ROW_ITEM, topk_pkg::CMD_READ,  32'd0, 32'd0, 5'd0, 1'b1, NO_ENTRY},
		'{ROW_ITEM, topk_pkg::CMD_OFFER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0, 1'b0, NO_ENTRY},
		'{ROW_ITEM, topk_pkg::CMD_READ,  32'd0, 32'd0, 5'd0, 1'b1, TOP_ENTRY},
		'{ROW_ITEM, topk_pkg::CMD_OFFER, 32'd0, 32'd0, 5'd0, 1'b0, NO_ENTRY},
		'{ROW_ITEM, topk_pkg::CMD_OFFER, 32'd1, 32'd0, 5'd0, 1'b0, NO_ENTRY},
		'{ROW_ITEM, topk_pkg::CMD_OFFER, 32'd2, 32'd5, 5'd0, 1'b0, NO_ENTRY},
		'{ROW_ITEM, topk_pkg::CMD_READ,  32'd0, 32'd0, 5'd0, 1'b0, NO_ENTRY},
		'{ROW_CFG,  topk_pkg::CMD_OFFER, 32'd0, 32'd0, 5'd1, 1'b0, NO_ENTRY},
		'{ROW_ITEM, topk_pkg::CMD_READ,  32'd0, 32'd0, 5'd0, 1'b1, NO_ENTRY},
		'{ROW_ITEM, topk_pkg::CMD_OFFER, 32'hA, 32'd10, 5'd0, 1'b0, NO_ENTRY},
		'{ROW_ITEM, topk_pkg::CMD_OFFER, 32'hB, 32'd10, 5'd0, 1'b0, NO_ENTRY},
		'{ROW_ITEM, topk_pkg::CMD_OFFER, 32'hC, 32'd11, 5'd0, 1'b0, NO_ENTRY},
		'{ROW_ITEM, topk_pkg::CMD_READ,  32'd0, 32'd0, 5'd0, 1'b0, NO_ENTRY},
		'{ROW_CFG,  topk_pkg::CMD_OFFER, 32'd0, 32'd0, 5'd0, 1'b0, NO_ENTRY},
		'{ROW_ITEM, topk_pkg::CMD_OFFER, 32'd5, 32'd0, 5'd0, 1'b0, NO_ENTRY},
		'{ROW_ITEM, topk_pkg::CMD_OFFER, 32'd6, 32'd1, 5'd0, 1'b0, NO_ENTRY},
		'{ROW_ITEM, topk_pkg::CMD_READ,  32'd0, 32'd0, 5'd0, 1'b0, NO_ENTRY},
		'{ROW_CFG,  topk_pkg::CMD_OFFER, 32'd0, 32'd0, 5'd31, 1'b0, NO_ENTRY},
		'{ROW_ITEM, topk_pkg::CMD_OFFER, 32'hAAAA_5555, 32'd7, 5'd0, 1'b0, NO_ENTRY},
		'{ROW_ITEM, topk_pkg::CMD_READ,  32'd0, 32'd0, 5'd0, 1'b0, NO_ENTRY},
		'{ROW_CFG,  topk_pkg::CMD_OFFER, 32'd0, 32'd0, 5'd2, 1'b0, NO_ENTRY},
		'{ROW_ITEM, topk_pkg::CMD_OFFER, 32'h55AA, 32'd3, 5'd0, 1'b0, NO_ENTRY},
		'{ROW_ITEM, topk_pkg::CMD_OFFER, 32'h77, 32'd9, 5'd0, 1'b0, NO_ENTRY},
		'{ROW_ITEM, topk_pkg::CMD_OFFER, 32'h88, 32'd1, 5'd0, 1'b0, NO_ENTRY},
		'{ROW_ITEM, topk_pkg::CMD_OFFER, 32'h99, 32'd5, 5'd0, 1'b0, NO_ENTRY},
		'{ROW_ITEM, topk_pkg::CMD_READ,  32'd0, 32'd0, 5'd0, 1'b0, NO_ENTRY}
	};

	top_k_frequency_tracker uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.command       (command),
		.offered_tag   (offered_tag),
		.offered_count (offered_count),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.kept_count    (kept_count),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.entry_valid   (entry_valid),
		.rank          (rank),
		.entry_tag     (entry_tag),
		.entry_count   (entry_count),
		.last          (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void rank_offer(input logic [topk_pkg::TAG_W-1:0] tag,
			input logic [topk_pkg::CNT_W-1:0] cnt);
		int pos;
		int top;
		int i;
		bit found;
		pos = held_fill;
		found = 1'b0;
		for (i = 0; i < held_fill; i++) begin
			if (!found && held_cnt[i] < cnt) begin
				pos = i;
				found = 1'b1;
			end
		end
		if (held_fill >= kept_limit) begin
			// full: an offer that beats nobody is dropped, otherwise the tail falls off
			if (!found)
				return;
			top = kept_limit - 1;
		end else begin
			top = held_fill;
			held_fill++;
		end
		for (i = top; i > pos; i--) begin
			held_tag[i] = held_tag[i-1];
			held_cnt[i] = held_cnt[i-1];
		end
		held_tag[pos] = tag;
		held_cnt[pos] = cnt;
	endfunction

	function automatic void list_readout();
		entry_t e;
		int i;
		if (held_fill == 0)
			pending_entries.push_back(NO_ENTRY);
		for (i = 0; i < held_fill; i++) begin
			e.valid = 1'b1;
			e.pos   = topk_pkg::RANK_W'(i);
			e.tag   = held_tag[i];
			e.cnt   = held_cnt[i];
			e.tail  = (i == held_fill - 1);
			pending_entries.push_back(e);
		end
	endfunction

	function automatic void apply_kept(input logic [topk_pkg::CFG_W-1:0] v);
		if (v == '0)
			kept_limit = 1;
		else if (int'(v) > topk_pkg::MAX_KEPT)
			kept_limit = topk_pkg::MAX_KEPT;
		else
			kept_limit = int'(v);
		held_fill = 0;
	endfunction

	function automatic string show(input entry_t e);
		return $sformatf("valid=%0b rank=%0d tag=%h count=%h last=%0b",
			e.valid, e.pos, e.tag, e.cnt, e.tail);
	endfunction

	function automatic void check_entry(input entry_t got);
		entry_t want;
		if (pending_entries.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t unexpected result: %s", $time, show(got));
			return;
		end
		want = pending_entries.pop_front();
		if (got.valid !== want.valid || got.pos !== want.pos || got.tag !== want.tag
				|| got.cnt !== want.cnt || got.tail !== want.tail) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t mismatch: expected %s, got %s", $time, show(want), show(got));
		end
	endfunction

	// Valid stays high between back-to-back items; it drops only ahead of a gap.
	task automatic send_item(input logic cmd, input logic [topk_pkg::TAG_W-1:0] tag,
			input logic [topk_pkg::CNT_W-1:0] cnt, input bit typed, input entry_t want);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid    <= 1'b1;
		command       <= cmd;
		offered_tag   <= tag;
		offered_count <= cnt;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		if (cmd == topk_pkg::CMD_OFFER)
			rank_offer(tag, cnt);
		else if (typed)
			pending_entries.push_back(want);
		else
			list_readout();
	endtask

	task automatic write_kept(input logic [topk_pkg::CFG_W-1:0] v);
		item_valid <= 1'b0;
		while (pending_entries.size() != 0) @(posedge clk);
		// an offer leaves nothing to wait on; let the last one settle
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid  <= 1'b1;
		kept_count <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		apply_kept(v);
	endtask

	always @(posedge clk) begin : result_sink
		entry_t got;
		int d;
		if (arst_n && result_valid === 1'b1 && !result_stall) begin
			got = '{entry_valid, rank, entry_tag, entry_count, last};
			check_entry(got);
			d = quiet ? 0 : $urandom_range(0, 16);
			result_stall <= (d != 0);
			hold_left    <= (d != 0) ? d - 1 : 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else begin
			// occasional random stall while no result transfer or hold is in progress
			result_stall <= !quiet && ($urandom_range(0, 7) == 0);
		end
	end

	initial begin : stimulus
		int k;
		int p;
		int n;
		logic [topk_pkg::CFG_W-1:0] setting;
		logic cmd;
		logic [topk_pkg::CNT_W-1:0] cnt;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (k = 0; k < N_ROWS; k++) begin
			if (dir_rows[k].kind == ROW_CFG)
				write_kept(dir_rows[k].kept);
			else
				send_item(dir_rows[k].cmd, dir_rows[k].tag, dir_rows[k].cnt,
					dir_rows[k].typed, dir_rows[k].want);
		end
		for (p = 0; p < N_PHASES; p++) begin
			case (p)
				0: setting = 5'd16;
				1: setting = 5'd1;
				2: setting = 5'd31;
				3: setting = 5'd0;
				4: setting = 5'd17;
				5: setting = 5'd4;
				default: setting = topk_pkg::CFG_W'($urandom_range(0, 31));
			endcase
			quiet = ($urandom_range(0, 3) == 0);
			write_kept(setting);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				cmd = ($urandom_range(0, 4) == 0) ? topk_pkg::CMD_READ : topk_pkg::CMD_OFFER;
				// small counts most of the time, so ties and tail drops are frequent
				case ($urandom_range(0, 9))
					0: cnt = '1;
					1: cnt = '0;
					2, 3: cnt = $urandom;
					default: cnt = $urandom_range(0, 12);
				endcase
				send_item(cmd, $urandom, cnt, 1'b0, NO_ENTRY);
			end
		end
		item_valid <= 1'b0;
		while (pending_entries.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
